>>> design/pressure_temperature_compensation_macros.svh
// assertion helpers shared by the compensation block
`ifndef PRESSURE_TEMPERATURE_COMPENSATION_MACROS_SVH
`define PRESSURE_TEMPERATURE_COMPENSATION_MACROS_SVH

// same-cycle implication, checked outside reset
`define PTC_ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ptc implication failed");

// next-cycle implication, checked outside reset
`define PTC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ptc next-cycle check failed");

`endif

>>> design/ptc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ptc_pkg;

  // output pressure format
  localparam int unsigned PressureFractionBits = 8;
  localparam int unsigned PressureShift = 16 - PressureFractionBits;

  // long division: quotient bits produced, one per stage
  localparam int unsigned DivSteps = 45;
  localparam int unsigned NumWidth = 76;
  localparam int unsigned DenWidth = 41;

  // accept edge to result edge
  localparam int unsigned Latency = 17 + DivSteps;

  // fixed-point constants
  localparam logic signed [25:0] TfineOffset = 26'sd128000;
  localparam logic signed [63:0] AccBias = 64'sh0000_8000_0000_0000;
  localparam logic [20:0] PressureFull = 21'd1048576;
  localparam logic [11:0] QuotScale = 12'd3125;
  localparam logic [DivSteps-1:0] QuotLimit = {1'b1, 44'd0};

  typedef enum logic [1:0] {
    CfgTempCal  = 2'd0,
    CfgPresLow  = 2'd1,
    CfgPresHigh = 2'd2,
    CfgPresNine = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [19:0] raw_pressure;
    logic [19:0] raw_temperature;
  } ptc_in_t;

  typedef struct packed {
    logic signed [15:0] temperature_centi;
    logic [31:0]        pressure_q24_8;
    logic               divide_fault;
  } ptc_out_t;

  // side data that rides along the divider
  typedef struct packed {
    logic signed [15:0] temp;
    logic               neg;
    logic               fault;
  } ptc_tag_t;

  typedef struct packed {
    logic [NumWidth-1:0] num;
    logic [DenWidth-1:0] den;
    ptc_tag_t            tag;
  } ptc_div_in_t;

  typedef struct packed {
    logic [DivSteps-1:0] quot;
    logic                sat;
    ptc_tag_t            tag;
  } ptc_div_out_t;

  typedef struct packed {
    logic [DenWidth-1:0] rem;
    logic [DivSteps-1:0] dq;
    logic [DenWidth-1:0] den;
    logic                sat;
    ptc_tag_t            tag;
  } ptc_div_stage_t;

endpackage
`default_nettype wire

>>> design/pressure_temperature_compensation.sv
`timescale 1ns / 1ps
`default_nettype none
`include "pressure_temperature_compensation_macros.svh"
// Barometric pressure and temperature compensation.
// Input channel: an item (raw pressure and raw temperature) is taken on a
// rising edge with start high and busy low. busy is high only while reset is
// being released, so one item can enter every cycle.
// Config channel: cfg_valid_i/cfg_ready_o, a register index and 64-bit data;
// the user must write calibration words only while no item is in flight; the
// block leaves this unchecked. Result channel: valid_o strobes for one cycle
// with result_o; the receiver cannot stall, so nothing is held back.
// Pipeline: the 46-register divider (entry plus 45 radix-2 steps) and
// 16 arithmetic stages around it lie between the accepting edge and the
// edge that takes the result.
// Throughput: one item per cycle.
// Reset: clears all valid bits and the calibration registers to zero; items
// in flight are dropped.
// A zero divisor gives pressure 0 with divide_fault set; temperature stays
// valid.
module pressure_temperature_compensation (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  ptc_pkg::ptc_in_t   in_i,
  output logic               valid_o,
  output ptc_pkg::ptc_out_t  result_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [63:0]        cfg_data_i
);

  logic        busy_q;
  logic        accept;
  logic [47:0] temp_cal_q;
  logic [63:0] pres_low_q;
  logic [63:0] pres_high_q;
  logic [15:0] pres_nine_q;

  logic [15:0]        t1, p1;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;

  logic [10:0] fv_q;
  logic [4:0]  bv_q;
  logic [19:0] rp_q [8];
  logic signed [15:0] temp_q [6];

  logic signed [18:0] d1_d, d1_q;
  logic signed [16:0] d2_d, d2_q;
  logic signed [34:0] m1_q;
  logic signed [33:0] sq_q;
  logic signed [23:0] tf1_q;
  logic signed [37:0] m2_q;
  logic signed [24:0] tfine_q;
  logic signed [27:0] t5, ts;
  logic signed [15:0] temp_d;
  logic signed [25:0] v1_q;
  logic signed [51:0] v1sq_q;
  logic signed [41:0] v1p5_f_q, v1p2_f_q, v1p5_g_q, v1p2_g_q;
  logic signed [63:0] t6_q, t3p_q;
  logic signed [63:0] v2_q, acc;
  logic signed [56:0] a_q;
  logic signed [56:0] x_hi_q;
  logic [32:0]        x_lo_q;
  logic [20:0]        pdiff;
  logic signed [64:0] num_q;
  logic signed [75:0] sumd;
  logic signed [41:0] div_q;
  logic [63:0]        an_q;
  logic               negn_q;
  logic [75:0]        nn_q;
  logic [40:0]        ad_q;
  ptc_pkg::ptc_tag_t  tag_k_q;

  ptc_pkg::ptc_div_in_t  div_in;
  ptc_pkg::ptc_div_out_t div_out;
  logic                  div_valid;

  logic [ptc_pkg::DivSteps-1:0] mag;
  logic signed [45:0] mag_s, p_d, p_m_q, p_n_q;
  ptc_pkg::ptc_tag_t  tag_m_q, tag_n_q, tag_o_q, tag_s_q;
  logic signed [45:0] q13;
  logic [31:0]        uq;
  logic [63:0]        q2_q;
  logic signed [61:0] e2p_q;
  logic signed [55:0] e1a_q;
  logic signed [41:0] e1b_q;
  logic signed [47:0] base_q;
  logic signed [57:0] s_q, r;
  logic [31:0]        pres_d;
  ptc_pkg::ptc_out_t  result_q;

  // control: reset release and calibration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b1;
      temp_cal_q  <= '0;
      pres_low_q  <= '0;
      pres_high_q <= '0;
      pres_nine_q <= '0;
    end else begin
      busy_q <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (ptc_pkg::cfg_reg_e'(cfg_index_i))
          ptc_pkg::CfgTempCal:  temp_cal_q  <= cfg_data_i[47:0];
          ptc_pkg::CfgPresLow:  pres_low_q  <= cfg_data_i;
          ptc_pkg::CfgPresHigh: pres_high_q <= cfg_data_i;
          ptc_pkg::CfgPresNine: pres_nine_q <= cfg_data_i[15:0];
        endcase
      end
    end
  end

  assign busy        = busy_q;
  assign cfg_ready_o = ~busy_q;
  assign accept      = start && !busy_q;

  // calibration words
  assign t1 = temp_cal_q[15:0];
  assign t2 = $signed(temp_cal_q[31:16]);
  assign t3 = $signed(temp_cal_q[47:32]);
  assign p1 = pres_low_q[15:0];
  assign p2 = $signed(pres_low_q[31:16]);
  assign p3 = $signed(pres_low_q[47:32]);
  assign p4 = $signed(pres_low_q[63:48]);
  assign p5 = $signed(pres_high_q[15:0]);
  assign p6 = $signed(pres_high_q[31:16]);
  assign p7 = $signed(pres_high_q[47:32]);
  assign p8 = $signed(pres_high_q[63:48]);
  assign p9 = $signed(pres_nine_q);

  // valid bits of the front and back sections
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= '0;
      bv_q <= '0;
    end else begin
      fv_q <= {fv_q[9:0], accept};
      bv_q <= {bv_q[3:0], div_valid};
    end
  end

  // raw pressure and temperature result delay lines
  always_ff @(posedge clk_i) begin
    rp_q[0] <= in_i.raw_pressure;
    for (int i = 1; i < 8; i++) begin
      rp_q[i] <= rp_q[i-1];
    end
    temp_q[0] <= temp_d;
    for (int i = 1; i < 6; i++) begin
      temp_q[i] <= temp_q[i-1];
    end
  end

  // temperature deltas
  assign d1_d = $signed({2'b0, in_i.raw_temperature[19:3]}) - $signed({2'b0, t1, 1'b0});
  assign d2_d = $signed({1'b0, in_i.raw_temperature[19:4]}) - $signed({1'b0, t1});

  // temperature output scaling and saturation
  always_comb begin
    t5 = 28'(tfine_q) * 28'sd5 + 28'sd128;
    ts = t5 >>> 8;
    if (ts > 28'sd32767) begin
      temp_d = 16'sh7fff;
    end else if (ts < -28'sd32768) begin
      temp_d = 16'sh8000;
    end else begin
      temp_d = 16'(ts);
    end
  end

  assign acc   = (t3p_q >>> 8) + (64'(v1p2_g_q) <<< 12);
  assign pdiff = ptc_pkg::PressureFull - 21'(rp_q[7]);
  assign sumd  = (76'(x_hi_q) <<< 17) + 76'($signed({1'b0, x_lo_q}));

  // front section: temperature polynomial, pressure numerator and divisor
  always_ff @(posedge clk_i) begin
    d1_q     <= d1_d;
    d2_q     <= d2_d;
    m1_q     <= 35'(d1_q) * 35'(t2);
    sq_q     <= 34'(d2_q) * 34'(d2_q);
    tf1_q    <= 24'(m1_q >>> 11);
    m2_q     <= 38'(22'(sq_q >>> 12)) * 38'(t3);
    tfine_q  <= 25'(tf1_q) + 25'(m2_q >>> 14);
    v1_q     <= 26'(tfine_q) - ptc_pkg::TfineOffset;
    v1sq_q   <= 52'(v1_q) * 52'(v1_q);
    v1p5_f_q <= 42'(v1_q) * 42'(p5);
    v1p2_f_q <= 42'(v1_q) * 42'(p2);
    t6_q     <= 64'(v1sq_q) * 64'(p6);
    t3p_q    <= 64'(v1sq_q) * 64'(p3);
    v1p5_g_q <= v1p5_f_q;
    v1p2_g_q <= v1p2_f_q;
    v2_q     <= t6_q + (64'(v1p5_g_q) <<< 17) + (64'(p4) <<< 35);
    a_q      <= 57'(acc + ptc_pkg::AccBias);
    x_hi_q   <= 57'(a_q >>> 17) * 57'($signed({1'b0, p1}));
    x_lo_q   <= 33'(a_q[16:0]) * 33'(p1);
    num_q    <= 65'($signed({1'b0, pdiff, 31'b0})) - 65'(v2_q);
    div_q    <= 42'(sumd >>> 33);
    an_q     <= num_q[64] ? 64'(-num_q) : 64'(num_q);
    negn_q   <= num_q[64];
    nn_q     <= 76'(an_q) * 76'(ptc_pkg::QuotScale);
    ad_q     <= 41'(div_q[41] ? -div_q : div_q);
    tag_k_q.temp  <= temp_q[5];
    tag_k_q.neg   <= negn_q ^ div_q[41];
    tag_k_q.fault <= (div_q == '0);
  end

  assign div_in.num = nn_q;
  assign div_in.den = ad_q;
  assign div_in.tag = tag_k_q;

  ptc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fv_q[10]),
    .div_i   (div_in),
    .valid_o (div_valid),
    .div_o   (div_out)
  );

  // quotient clamp and sign
  always_comb begin
    if (div_out.sat || (div_out.quot > ptc_pkg::QuotLimit)) begin
      mag = ptc_pkg::QuotLimit;
    end else begin
      mag = div_out.quot;
    end
    mag_s = $signed({1'b0, mag});
    p_d   = div_out.tag.neg ? -mag_s : mag_s;
  end

  assign q13 = p_m_q >>> 13;
  assign uq  = q13[45] ? 32'(-q13) : 32'(q13);

  // final clamp to the output range
  always_comb begin
    r = s_q >>> ptc_pkg::PressureShift;
    if (tag_s_q.fault || r < 58'sd0) begin
      pres_d = '0;
    end else if (r > 58'sd4294967295) begin
      pres_d = '1;
    end else begin
      pres_d = r[31:0];
    end
  end

  // back section: second-order correction and offset
  always_ff @(posedge clk_i) begin
    p_m_q   <= p_d;
    tag_m_q <= div_out.tag;
    q2_q    <= 64'(uq) * 64'(uq);
    e2p_q   <= 62'(p_m_q) * 62'(p8);
    p_n_q   <= p_m_q;
    tag_n_q <= tag_m_q;
    e1a_q   <= 56'($signed({1'b0, q2_q[63:25]})) * 56'(p9);
    e1b_q   <= 42'($signed({1'b0, q2_q[24:0]})) * 42'(p9);
    base_q  <= 48'(p_n_q) + 48'(e2p_q >>> 19) + (48'(p7) <<< 12);
    tag_o_q <= tag_n_q;
    s_q     <= 58'(e1a_q) + 58'(base_q) + 58'(e1b_q >>> 25);
    tag_s_q <= tag_o_q;
    result_q.temperature_centi <= tag_s_q.temp;
    result_q.pressure_q24_8    <= pres_d;
    result_q.divide_fault      <= tag_s_q.fault;
  end

  assign valid_o  = bv_q[4];
  assign result_o = result_q;

  // checks
  `PTC_ASSERT_IMPLIES(a_latency, clk_i, rst_ni, start && !busy, ##(ptc_pkg::Latency) valid_o)
  `PTC_ASSERT_IMPLIES(a_no_spurious, clk_i, rst_ni, valid_o, $past(start && !busy, ptc_pkg::Latency))
  `PTC_ASSERT_IMPLIES(a_fault_zero, clk_i, rst_ni, valid_o && result_o.divide_fault, result_o.pressure_q24_8 == '0)
  `PTC_ASSERT_NEXT(a_cfg_nine, clk_i, rst_ni, cfg_valid_i && cfg_ready_o && cfg_index_i == ptc_pkg::CfgPresNine, pres_nine_q == $past(cfg_data_i[15:0]))

endmodule
`default_nettype wire

>>> design/ptc_div.sv
`timescale 1ns / 1ps
`default_nettype none
module ptc_div (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  ptc_pkg::ptc_div_in_t   div_i,
  output logic                   valid_o,
  output ptc_pkg::ptc_div_out_t  div_o
);

  logic [ptc_pkg::DivSteps:0] vld_q;
  ptc_pkg::ptc_div_stage_t    stage_q [ptc_pkg::DivSteps+1];
  ptc_pkg::ptc_div_stage_t    entry_d;
  logic [ptc_pkg::NumWidth-ptc_pkg::DivSteps-1:0] head;

  // entry: top bits seed the remainder, overflow when they already reach the divisor
  always_comb begin
    head          = div_i.num[ptc_pkg::NumWidth-1:ptc_pkg::DivSteps];
    entry_d.rem   = ptc_pkg::DenWidth'(head);
    entry_d.dq    = div_i.num[ptc_pkg::DivSteps-1:0];
    entry_d.den   = div_i.den;
    entry_d.sat   = ptc_pkg::DenWidth'(head) >= div_i.den;
    entry_d.tag   = div_i.tag;
  end

  // valid bits travel with the stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[ptc_pkg::DivSteps-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    stage_q[0] <= entry_d;
  end

  // one restoring step per stage
  for (genvar i = 0; i < ptc_pkg::DivSteps; i++) begin : g_step
    logic [ptc_pkg::DenWidth:0] trial;
    logic                       fits;
    ptc_pkg::ptc_div_stage_t    step_d;

    always_comb begin
      trial       = {stage_q[i].rem, stage_q[i].dq[ptc_pkg::DivSteps-1]};
      fits        = trial >= {1'b0, stage_q[i].den};
      step_d      = stage_q[i];
      step_d.rem  = fits ? ptc_pkg::DenWidth'(trial - {1'b0, stage_q[i].den})
                         : trial[ptc_pkg::DenWidth-1:0];
      step_d.dq   = {stage_q[i].dq[ptc_pkg::DivSteps-2:0], fits};
    end

    always_ff @(posedge clk_i) begin
      stage_q[i+1] <= step_d;
    end
  end

  assign valid_o    = vld_q[ptc_pkg::DivSteps];
  assign div_o.quot = stage_q[ptc_pkg::DivSteps].dq;
  assign div_o.sat  = stage_q[ptc_pkg::DivSteps].sat;
  assign div_o.tag  = stage_q[ptc_pkg::DivSteps].tag;

endmodule
`default_nettype wire

>>> test/tb.sv
`timescale 1ns / 1ps
module tb;

  localparam int unsigned CycleLimit = 400000;
  localparam longint PresMax = 64'sh0000_0000_FFFF_FFFF;
  localparam longint unsigned QuotCap = 64'd1 << 44;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  ptc_pkg::ptc_in_t   in_i = '0;
  logic               valid_o;
  ptc_pkg::ptc_out_t  result_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i = ptc_pkg::CfgTempCal;
  logic [63:0]        cfg_data_i = '0;

  // calibration copies seen by the predictor
  logic [47:0] temp_cal = '0;
  logic [63:0] pres_cal_lo = '0;
  logic [63:0] pres_cal_hi = '0;
  logic [15:0] pres_nine = '0;

  ptc_pkg::ptc_in_t  pending_items[$];
  ptc_pkg::ptc_out_t expected_readings[$];
  int       gap_left = 0;
  int       mismatches = 0;
  int       cycles = 0;

  pressure_temperature_compensation dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .in_i(in_i),
    .valid_o(valid_o), .result_o(result_o), .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o), .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // compensated temperature and pressure for one reading pair
  function automatic ptc_pkg::ptc_out_t compensate(ptc_pkg::ptc_in_t x);
    longint adc_p, adc_t, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    longint d1, d2, tf, tc, v1, v2, acc, dv, num, p, q, e1, e2, s, r, hi, lo;
    longint unsigned an, ad, qa, ra, mag, uq, q2;
    logic signed [127:0] wa, wb, wide;
    logic neg;
    ptc_pkg::ptc_out_t o;
    adc_p = longint'(x.raw_pressure);
    adc_t = longint'(x.raw_temperature);
    t1 = longint'(temp_cal[15:0]);
    t2 = $signed(temp_cal[31:16]);
    t3 = $signed(temp_cal[47:32]);
    p1 = longint'(pres_cal_lo[15:0]);
    p2 = $signed(pres_cal_lo[31:16]);
    p3 = $signed(pres_cal_lo[47:32]);
    p4 = $signed(pres_cal_lo[63:48]);
    p5 = $signed(pres_cal_hi[15:0]);
    p6 = $signed(pres_cal_hi[31:16]);
    p7 = $signed(pres_cal_hi[47:32]);
    p8 = $signed(pres_cal_hi[63:48]);
    p9 = $signed(pres_nine);
    o = '0;
    // fine temperature and centidegrees
    d1 = (adc_t >>> 3) - t1 * 2;
    d2 = (adc_t >>> 4) - t1;
    tf = ((d1 * t2) >>> 11) + ((((d2 * d2) >>> 12) * t3) >>> 14);
    tc = (tf * 5 + 128) >>> 8;
    if (tc > 32767) tc = 32767;
    if (tc < -32768) tc = -32768;
    o.temperature_centi = tc[15:0];
    // divisor: floor(acc' * p1 / 2^33), exact in wide arithmetic
    v1 = tf - 128000;
    v2 = v1 * v1 * p6 + v1 * p5 * 131072 + p4 * (64'sd1 <<< 35);
    acc = ((v1 * v1 * p3) >>> 8) + v1 * p2 * 4096;
    wa = 128'((64'sd1 <<< 47) + acc);
    wb = 128'(p1);
    wide = wa * wb;
    dv = wide[96:33];
    if (dv == 0) begin
      o.divide_fault = 1'b1;
    end else begin
      num = ((64'sd1048576 - adc_p) <<< 31) - v2;
      neg = (num < 0) != (dv < 0);
      an = (num < 0) ? -num : num;
      ad = (dv < 0) ? -dv : dv;
      qa = an / ad;
      ra = an % ad;
      if (qa > QuotCap) begin
        mag = QuotCap;
      end else begin
        mag = qa * 3125 + (ra * 3125) / ad;
        if (mag > QuotCap) mag = QuotCap;
      end
      p = mag;
      if (neg) p = -p;
      // second-order correction
      q = p >>> 13;
      uq = (q < 0) ? -q : q;
      q2 = uq * uq;
      hi = q2 >> 25;
      lo = q2 & 64'h1FF_FFFF;
      e1 = hi * p9 + ((lo * p9) >>> 25);
      e2 = (p8 * p) >>> 19;
      s = p + e1 + e2 + p7 * 4096;
      r = s >>> (16 - ptc_pkg::PressureFractionBits);
      if (r < 0) r = 0;
      if (r > PresMax) r = PresMax;
      o.pressure_q24_8 = r[31:0];
    end
    return o;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // driver: feeds pending items, records expectations on acceptance
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) expected_readings.push_back(compensate(in_i));
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          start <= 1'b0;
        end else if (pending_items.size() > 0) begin
          start <= 1'b1;
          in_i <= pending_items.pop_front();
          gap_left = pick_gap();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // calibration copies follow accepted writes
  always @(posedge clk_i) begin
    if (rst_ni && cfg_valid_i && cfg_ready_o) begin
      case (ptc_pkg::cfg_reg_e'(cfg_index_i))
        ptc_pkg::CfgTempCal:  temp_cal <= cfg_data_i[47:0];
        ptc_pkg::CfgPresLow:  pres_cal_lo <= cfg_data_i;
        ptc_pkg::CfgPresHigh: pres_cal_hi <= cfg_data_i;
        ptc_pkg::CfgPresNine: pres_nine <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // monitor: compare each result with the oldest expectation
  always @(posedge clk_i) begin
    ptc_pkg::ptc_out_t want;
    if (rst_ni && valid_o) begin
      if (expected_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", result_o);
      end else begin
        want = expected_readings.pop_front();
        if (result_o.temperature_centi !== want.temperature_centi ||
            result_o.pressure_q24_8 !== want.pressure_q24_8 ||
            result_o.divide_fault !== want.divide_fault) begin
          mismatches++;
          if (mismatches <= 10)
            $display("temp exp %0d got %0d, pres exp %h got %h, fault exp %b got %b",
                     want.temperature_centi, result_o.temperature_centi,
                     want.pressure_q24_8, result_o.pressure_q24_8,
                     want.divide_fault, result_o.divide_fault);
        end
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // holds the write until it is taken; the caller drops valid after the last one
  task automatic write_reg(input ptc_pkg::cfg_reg_e idx, input logic [63:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic load_cal(input logic [47:0] t, input logic [63:0] lo, input logic [63:0] hi,
                          input logic [15:0] nine);
    write_reg(ptc_pkg::CfgTempCal, {16'($urandom), t});
    write_reg(ptc_pkg::CfgPresLow, lo);
    write_reg(ptc_pkg::CfgPresHigh, hi);
    write_reg(ptc_pkg::CfgPresNine, {$urandom, 16'($urandom), nine});
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic add(input logic [19:0] rp, input logic [19:0] rt);
    ptc_pkg::ptc_in_t it;
    it.raw_pressure = rp;
    it.raw_temperature = rt;
    pending_items.push_back(it);
  endtask

  // random readings: mostly near operating range, some anywhere
  task automatic add_random(input int n);
    repeat (n) begin
      if ($urandom_range(0, 3) == 0) add(20'($urandom), 20'($urandom));
      else add(20'($urandom_range(250000, 700000)), 20'($urandom_range(400000, 600000)));
    end
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || start || expected_readings.size() > 0)
      @(posedge clk_i);
    repeat (ptc_pkg::Latency + 4) @(posedge clk_i);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset calibration: zero divisor everywhere
    add(20'd0, 20'd0);
    add(20'hFFFFF, 20'hFFFFF);
    add(20'd415148, 20'd519888);
    drain();

    // typical factory calibration, directed corners then random
    load_cal({16'hFC18, 16'd26435, 16'd27504},
             {16'd2855, 16'd3024, 16'hD643, 16'd36477},
             {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140}, 16'd6000);
    add(20'd0, 20'd0);
    add(20'hFFFFF, 20'd0);
    add(20'd0, 20'hFFFFF);
    add(20'hFFFFF, 20'hFFFFF);
    add(20'h80000, 20'h80000);
    add(20'h7FFFF, 20'h7FFFF);
    add(20'd415148, 20'd519888);
    add(20'd415148, 20'd0);
    add(20'd1, 20'd440064);
    add(20'hAAAAA, 20'h55555);
    add(20'h55555, 20'hAAAAA);
    add_random(140);
    drain();

    // all words at their largest
    load_cal({16'h7FFF, 16'h7FFF, 16'hFFFF}, {{3{16'h7FFF}}, 16'hFFFF},
             {4{16'h7FFF}}, 16'h7FFF);
    add(20'd0, 20'd0);
    add(20'hFFFFF, 20'hFFFFF);
    add_random(30);
    drain();

    // most negative words, tiny p1 for huge quotients
    load_cal({16'h8000, 16'h8000, 16'h0000}, {{3{16'h8000}}, 16'h0001},
             {4{16'h8000}}, 16'h8000);
    add(20'd0, 20'hFFFFF);
    add(20'hFFFFF, 20'd0);
    add_random(30);
    drain();

    // random calibration sets
    repeat (4) begin
      load_cal(48'({$urandom, $urandom}), {$urandom, $urandom}, {$urandom, $urandom},
               16'($urandom));
      add_random(60);
      drain();
    end

    if (mismatches == 0 && expected_readings.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> pressure_temperature_compensation.f
+incdir+design
design/ptc_pkg.sv
design/ptc_div.sv
design/pressure_temperature_compensation.sv
test/tb.sv
